/* hdl/sab_pkg.sv */
// Package for the suffix automaton builder.
// Holds the fixed field widths and the sequencer state type; no dependencies.
`timescale 1ns / 1ps

package sab_pkg;

  localparam int unsigned LETTER_W = 5;   // input letter field
  localparam int unsigned IDX_W    = 13;  // new_state and state_count fields
  localparam int unsigned IN_W     = 8;   // s_axis_tdata width
  localparam int unsigned OUT_W    = 32;  // m_axis_tdata width

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_ZERO,
    ST_WALK,
    ST_CHKQ,
    ST_CL_Q,
    ST_CL_NP,
    ST_RED,
    ST_DONE
  } seq_state_e;

endpackage

/* hdl/suffix_automaton_builder_core.sv */
// Suffix automaton builder: online construction, one letter per transaction.
// Node (length, link) and transition rows live in two synchronous memories.
// Depends on sab_pkg.
//
//  channel  dir  fields (lsb up)                          handshake
//  s_axis   in   tdata: letter[4:0]                       tvalid/tready
//  m_axis   out  tdata: new_state[12:0], count[25:13]     tvalid/tready
//                tuser: overflow
//
// Steps: a dropped or ignored letter goes straight to DONE; an accepted one passes
// through INIT and ZERO, then a WALK step per state on the suffix-link walk, plus
// a CHKQ check of the target when the walk meets an existing transition; a clone
// adds CL_Q and CL_NP, then a RED step per state visited while redirecting. Each
// link step is a registered read of both memories and a write. A whole transition
// row is one memory word, so a clone copies it with one write.
// Reset clears control only; rows are zeroed as states are created, the root
// row reads as zero until first written. No clearing pass.
// A new letter is taken once the previous result sits in the output register.
`timescale 1ns / 1ps

module suffix_automaton_builder_core #(
  parameter int unsigned MAX_STATES = 8192,
  parameter int unsigned ALPHABET   = 26
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [sab_pkg::IN_W-1:0]    s_axis_tdata_i,   // letter
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [sab_pkg::OUT_W-1:0]   m_axis_tdata_o,   // new_state, state_count
  output logic                        m_axis_tuser_o    // overflow
);

  localparam int unsigned SW = $clog2(MAX_STATES);
  localparam int unsigned AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int unsigned NW = 2 * SW;

  typedef logic [ALPHABET-1:0][SW-1:0] row_t;

  // memories
  logic [NW-1:0] node_mem [MAX_STATES];
  row_t          trans_mem [MAX_STATES];

  logic          rd_en;
  logic [SW-1:0] rd_addr, rd_addr_q;
  logic [NW-1:0] node_raw_q;
  row_t          row_raw_q;
  logic          nwe, twe;
  logic [SW-1:0] nwaddr, twaddr;
  logic [NW-1:0] nwdata;
  row_t          twdata;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      node_raw_q <= node_mem[rd_addr];
      row_raw_q  <= trans_mem[rd_addr];
      rd_addr_q  <= rd_addr;
    end
    if (nwe) node_mem[nwaddr] <= nwdata;
    if (twe) trans_mem[twaddr] <= twdata;
  end

  sab_pkg::seq_state_e state_q, state_d;
  logic [SW-1:0] p_q, p_d, np_q, np_d, q_q, q_d, nq_q, nq_d;
  logic [SW-1:0] used_q, used_d, last_q, last_d;
  logic [SW-1:0] lenp_q, lenp_d, lennp_q, lennp_d, lenq_q, lenq_d;
  logic [SW-1:0] res_new_q, res_new_d;
  logic          res_ovf_q, res_ovf_d;
  logic [AW-1:0] c_q, c_d;
  logic          root_valid_q;
  logic          out_valid_q, out_load;
  logic [SW-1:0] out_new_q, out_cnt_q;
  logic          out_ovf_q;

  // root node is never written: length 0, link 0
  logic [SW-1:0] rd_len, rd_link, t_ent;
  row_t          row_rd, row_mod;
  logic [sab_pkg::LETTER_W-1:0] letter;
  logic          accept, bad_letter, full;

  assign letter     = s_axis_tdata_i[sab_pkg::LETTER_W-1:0];
  assign accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign bad_letter = {1'b0, 9'(letter)} >= 10'(ALPHABET);
  assign full       = ({1'b0, used_q} + (SW+1)'(2)) >= (SW+1)'(MAX_STATES);

  always_comb begin
    if (rd_addr_q == SW'(1)) begin
      rd_len  = '0;
      rd_link = '0;
    end else begin
      rd_len  = node_raw_q[NW-1:SW];
      rd_link = node_raw_q[SW-1:0];
    end
    row_rd = (rd_addr_q == SW'(1) && !root_valid_q) ? '0 : row_raw_q;
    t_ent  = row_rd[c_q];
  end

  always_comb begin
    state_d   = state_q;
    p_d       = p_q;
    np_d      = np_q;
    q_d       = q_q;
    nq_d      = nq_q;
    used_d    = used_q;
    last_d    = last_q;
    lenp_d    = lenp_q;
    lennp_d   = lennp_q;
    lenq_d    = lenq_q;
    res_new_d = res_new_q;
    res_ovf_d = res_ovf_q;
    c_d       = c_q;
    rd_en     = 1'b0;
    rd_addr   = p_q;
    nwe       = 1'b0;
    nwaddr    = np_q;
    nwdata    = '0;
    twe       = 1'b0;
    twaddr    = p_q;
    twdata    = '0;
    row_mod   = row_rd;
    out_load  = 1'b0;
    s_axis_tready_o = (state_q == sab_pkg::ST_IDLE);

    unique case (state_q)
      sab_pkg::ST_IDLE: begin
        if (accept) begin
          c_d       = AW'(letter);
          res_ovf_d = 1'b0;
          res_new_d = '0;
          if (bad_letter) begin
            state_d = sab_pkg::ST_DONE;
          end else if (full) begin
            res_ovf_d = 1'b1;
            state_d   = sab_pkg::ST_DONE;
          end else begin
            p_d       = last_q;
            np_d      = used_q + SW'(1);
            used_d    = used_q + SW'(1);
            last_d    = used_q + SW'(1);
            res_new_d = used_q + SW'(1);
            rd_en     = 1'b1;
            rd_addr   = last_q;
            state_d   = sab_pkg::ST_INIT;
          end
        end
      end
      sab_pkg::ST_INIT: begin
        lennp_d = rd_len + SW'(1);
        nwe     = 1'b1;
        nwaddr  = np_q;
        nwdata  = {rd_len + SW'(1), SW'(0)};
        state_d = sab_pkg::ST_ZERO;
      end
      sab_pkg::ST_ZERO: begin
        twe     = 1'b1;
        twaddr  = np_q;
        twdata  = '0;
        rd_en   = 1'b1;
        rd_addr = p_q;
        state_d = sab_pkg::ST_WALK;
      end
      sab_pkg::ST_WALK: begin
        lenp_d = rd_len;
        if (t_ent == '0) begin
          row_mod[c_q] = np_q;
          twe    = 1'b1;
          twaddr = p_q;
          twdata = row_mod;
          if (rd_link == '0) begin
            nwe     = 1'b1;
            nwaddr  = np_q;
            nwdata  = {lennp_q, SW'(1)};
            state_d = sab_pkg::ST_DONE;
          end else begin
            p_d     = rd_link;
            rd_en   = 1'b1;
            rd_addr = rd_link;
          end
        end else begin
          q_d     = t_ent;
          rd_en   = 1'b1;
          rd_addr = t_ent;
          state_d = sab_pkg::ST_CHKQ;
        end
      end
      sab_pkg::ST_CHKQ: begin
        if (rd_len == lenp_q + SW'(1)) begin
          nwe     = 1'b1;
          nwaddr  = np_q;
          nwdata  = {lennp_q, q_q};
          state_d = sab_pkg::ST_DONE;
        end else begin
          // clone q: copy its row and link in one go
          nq_d    = used_q + SW'(1);
          used_d  = used_q + SW'(1);
          twe     = 1'b1;
          twaddr  = used_q + SW'(1);
          twdata  = row_rd;
          nwe     = 1'b1;
          nwaddr  = used_q + SW'(1);
          nwdata  = {lenp_q + SW'(1), rd_link};
          lenq_d  = rd_len;
          state_d = sab_pkg::ST_CL_Q;
        end
      end
      sab_pkg::ST_CL_Q: begin
        nwe     = 1'b1;
        nwaddr  = q_q;
        nwdata  = {lenq_q, nq_q};
        state_d = sab_pkg::ST_CL_NP;
      end
      sab_pkg::ST_CL_NP: begin
        nwe     = 1'b1;
        nwaddr  = np_q;
        nwdata  = {lennp_q, nq_q};
        rd_en   = 1'b1;
        rd_addr = p_q;
        state_d = sab_pkg::ST_RED;
      end
      sab_pkg::ST_RED: begin
        if (t_ent == q_q) begin
          row_mod[c_q] = nq_q;
          twe    = 1'b1;
          twaddr = p_q;
          twdata = row_mod;
          if (rd_link == '0) begin
            state_d = sab_pkg::ST_DONE;
          end else begin
            p_d     = rd_link;
            rd_en   = 1'b1;
            rd_addr = rd_link;
          end
        end else begin
          state_d = sab_pkg::ST_DONE;
        end
      end
      sab_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = sab_pkg::ST_IDLE;
        end
      end
      default: state_d = sab_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sab_pkg::ST_IDLE;
      used_q       <= SW'(1);
      last_q       <= SW'(1);
      root_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      last_q  <= last_d;
      if (twe && twaddr == SW'(1)) root_valid_q <= 1'b1;
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q       <= p_d;
    np_q      <= np_d;
    q_q       <= q_d;
    nq_q      <= nq_d;
    lenp_q    <= lenp_d;
    lennp_q   <= lennp_d;
    lenq_q    <= lenq_d;
    res_new_q <= res_new_d;
    res_ovf_q <= res_ovf_d;
    c_q       <= c_d;
    if (out_load) begin
      out_new_q <= res_new_q;
      out_cnt_q <= used_q;
      out_ovf_q <= res_ovf_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_ovf_q;
  assign m_axis_tdata_o  = {(sab_pkg::OUT_W - 2*sab_pkg::IDX_W)'(0),
                            sab_pkg::IDX_W'(out_cnt_q), sab_pkg::IDX_W'(out_new_q)};

  a_used_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q != '0) else $error("state count dropped to zero");

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q != $past(used_q) |-> used_q == $past(used_q) + SW'(1))
    else $error("state count moved by other than one");

  a_walk_p: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sab_pkg::ST_WALK || state_q == sab_pkg::ST_RED) |-> p_q != '0)
    else $error("walk on the null state");

  a_row_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    twe |-> (twaddr <= used_d && twaddr != '0))
    else $error("transition row written beyond states in use");

endmodule
